@@ design/htd_pkg.sv @@
// shared types and constants of the huffman table decoder
`default_nettype none
package htd_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int BYTE_BITS        = 8;
    localparam int LEN_CMP_W        = 7;

    // configuration register indexes
    localparam logic REG_SYMBOL_TOTAL   = 1'b0;
    localparam logic REG_ENTRIES_IN_USE = 1'b1;

    // command kinds handed from front to back
    localparam logic [1:0] KIND_NOP    = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_DECODE = 2'd2;

    typedef struct packed {
        logic [31:0] code;
        logic [5:0]  length;
        logic [7:0]  symbol;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry_index;
        entry_t      entry;
        logic [7:0]  data_byte;
    } cmd_t;

endpackage
`default_nettype wire

@@ design/htd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ design/htd_front.sv @@
// input side: accepts beats, classifies them and queues up to two commands
`default_nettype none
module htd_front
    import htd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  wire logic        cmd_pop
);
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    cmd_t       new_cmd;
    logic       push;
    logic       pop;
    logic [1:0] slot;

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[0];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;
    assign slot      = cnt_reg - {1'b0, pop};

    // classify the beat
    always_comb begin
        new_cmd.entry_index  = s_tdata[7:0];
        new_cmd.entry.code   = s_tdata[39:8];
        new_cmd.entry.length = s_tdata[45:40];
        new_cmd.entry.symbol = s_tdata[53:46];
        new_cmd.data_byte    = s_tdata[61:54];
        if (s_tuser) begin
            new_cmd.kind = KIND_DECODE;
        end else if ({1'b0, s_tdata[7:0]} < 9'(TABLE_DEPTH)) begin
            new_cmd.kind = KIND_WRITE;
        end else begin
            new_cmd.kind = KIND_NOP;
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue payload: the head takes a new beat when free, else the tail moves up
    always_ff @(posedge aclk) begin
        if (push && !slot[0]) begin
            q_reg[0] <= new_cmd;
        end else if (pop) begin
            q_reg[0] <= q_reg[1];
        end
        if (push && slot[0]) begin
            q_reg[1] <= new_cmd;
        end
    end
endmodule
`default_nettype wire

@@ design/htd_back.sv @@
// execution side: table writes, bit serial decode with table scan, result output
`default_nettype none
module htd_back
    import htd_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_RES   = 3'd4;
    localparam logic [2:0] ST_NEXT  = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      acc_reg, acc_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [31:0]      count_reg, count_next;
    logic [31:0]      total_reg, total_next;
    logic [8:0]       entries_reg, entries_next;
    logic [7:0]       byte_reg, byte_next;
    logic [2:0]       bit_reg, bit_next;
    logic [8:0]       idx_reg, idx_next;
    logic [2**LW-1:0] flag_reg, flag_next;
    logic [7:0]       res_sym_reg, res_sym_next;
    logic             res_err_reg, res_err_next;
    logic             res_fin_reg, res_fin_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_sym_reg, pend_sym_next;
    logic             pend_err_reg, pend_err_next;
    logic             pend_fin_reg, pend_fin_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_sym_reg, out_sym_next;
    logic             out_err_reg, out_err_next;
    logic             out_fin_reg, out_fin_next;
    logic             out_last_reg, out_last_next;

    logic             ram_wr_en;
    logic             ram_rd_en;
    entry_t           ram_rd_data;
    logic [8:0]       limit;
    logic             out_free;
    logic             hit;

    htd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(cmd.entry_index)),
        .wr_data (cmd.entry),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign limit    = (entries_reg > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : entries_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign hit      = (LEN_CMP_W'(ram_rd_data.length) == LEN_CMP_W'(len_reg))
                      && (ram_rd_data.code == acc_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = {out_fin_reg, out_err_reg};
    assign m_tlast  = out_last_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        len_next        = len_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        entries_next    = entries_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        flag_next       = flag_reg;
        res_sym_next    = res_sym_reg;
        res_err_next    = res_err_reg;
        res_fin_next    = res_fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        pend_fin_next   = pend_fin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_fin_next    = out_fin_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        KIND_WRITE: begin
                            ram_wr_en = 1'b1;
                            if (LEN_CMP_W'(cmd.entry.length) <= LEN_CMP_W'(MAX_CODE_LEN)) begin
                                flag_next[LW'(cmd.entry.length)] = 1'b1;
                            end
                        end
                        KIND_DECODE: begin
                            if (count_reg != total_reg) begin
                                byte_next  = cmd.data_byte;
                                bit_next   = 3'd0;
                                state_next = ST_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                acc_next   = {acc_reg[30:0], byte_reg[7]};
                byte_next  = {byte_reg[6:0], 1'b0};
                len_next   = len_reg + 1'b1;
                idx_next   = 9'd0;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (flag_reg[len_reg] && (idx_reg < limit)) begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_CMP;
                end else if (len_reg >= LW'(MAX_CODE_LEN)) begin
                    res_sym_next = 8'd0;
                    res_err_next = 1'b1;
                    res_fin_next = 1'b0;
                    acc_next     = 32'd0;
                    len_next     = '0;
                    state_next   = ST_RES;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_CMP: begin
                if (hit) begin
                    res_sym_next = ram_rd_data.symbol;
                    res_err_next = 1'b0;
                    res_fin_next = ((count_reg + 32'd1) == total_reg);
                    count_next   = count_reg + 32'd1;
                    acc_next     = 32'd0;
                    len_next     = '0;
                    state_next   = ST_RES;
                end else begin
                    idx_next   = idx_reg + 9'd1;
                    state_next = ST_LOOK;
                end
            end
            ST_RES: begin
                // hold one result back so the last of a byte can be marked
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = pend_sym_reg;
                        out_err_next   = pend_err_reg;
                        out_fin_next   = pend_fin_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_sym_next   = res_sym_reg;
                    pend_err_next   = res_err_reg;
                    pend_fin_next   = res_fin_reg;
                    state_next      = res_fin_reg ? ST_FLUSH : ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (bit_reg == 3'(BYTE_BITS - 1)) begin
                    state_next = ST_FLUSH;
                end else begin
                    bit_next   = bit_reg + 3'd1;
                    state_next = ST_SHIFT;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_err_next    = pend_err_reg;
                    out_fin_next    = pend_fin_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SYMBOL_TOTAL: begin
                    total_next = cfg_wr_data;
                    count_next = 32'd0;
                    acc_next   = 32'd0;
                    len_next   = '0;
                end
                REG_ENTRIES_IN_USE: begin
                    entries_next = cfg_wr_data[8:0];
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_reg        <= 32'd0;
            len_reg        <= '0;
            count_reg      <= 32'd0;
            total_reg      <= 32'd0;
            entries_reg    <= 9'd0;
            flag_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            entries_reg    <= entries_next;
            flag_reg       <= flag_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        bit_reg      <= bit_next;
        idx_reg      <= idx_next;
        res_sym_reg  <= res_sym_next;
        res_err_reg  <= res_err_next;
        res_fin_reg  <= res_fin_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        pend_fin_reg <= pend_fin_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_fin_reg  <= out_fin_next;
        out_last_reg <= out_last_next;
    end
endmodule
`default_nettype wire

@@ design/huffman_table_decoder_top.sv @@
// Huffman table decoder: a loaded code table turns encoded bytes into symbols.
// Input stream s_*: s_tuser = 0 writes one table entry, s_tuser = 1 decodes
// the byte in s_tdata[61:54]. Result stream m_*: one beat per decoded symbol
// or error; m_tlast marks the last result of an input byte.
// Config port: cfg_wr_en writes cfg_wr_data to register cfg_index
// (0 symbol total, which also clears decode progress; 1 entries in use).
// Table writes are handled in the back end. A decode byte walks 8 code bits,
// one at a time; when some entry has the current code length, the entries in
// use are scanned for a match through the single table read port. A result
// waits in a pending register until the next result or the end of its byte
// moves it to the output register, so the last result of a byte can be
// marked; the finishing result drops the rest of its byte. A two-beat queue
// in front lets the source run ahead; when m_tready is low the back end
// waits at the output register while the queue keeps filling. Reset clears
// progress, both registers and the length filter; the table contents stay
// undefined until written.
`default_nettype none
module huffman_table_decoder_top
    import htd_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[7:0], entry_code[39:8], entry_length[45:40],
    // entry_symbol[53:46], data_byte[61:54], zero fill
    input  wire logic [63:0] s_tdata,
    // opcode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // symbol
    output logic [7:0]       m_tdata,
    // error[0], finished[1]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    htd_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    htd_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // error beats carry no symbol and never finish
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && !m_tuser[1]))
        else $error("error beat with symbol or finish");

    // the finishing result closes its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("finished beat not marked last");
endmodule
`default_nettype wire
